// ===== rtl/npq_pkg.sv =====
package npq_pkg;

   // palette geometry
   localparam int PALETTE_DEPTH = 16;
   localparam int CELL_W        = $clog2(PALETTE_DEPTH);
   localparam int COUNT_W       = $clog2(PALETTE_DEPTH + 1);

   // field widths
   localparam int ENTRY_W = 4;
   localparam int CHAN_W  = 8;
   localparam int DIST_W  = 18;
   localparam int SIZE_W  = 5;
   localparam int MATCH_W = (CELL_W > ENTRY_W) ? CELL_W : ENTRY_W;

   // stream packing
   localparam int REQ_FIELD_W = ENTRY_W + 3 * CHAN_W;
   localparam int REQ_DATA_W  = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = ENTRY_W + 3 * CHAN_W + DIST_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [DIST_W-1:0] DIST_INIT = '1;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_PIXEL = 1'b1
   } mode_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } color_type;

   // item travelling along the row of cells, with the running best match
   typedef struct packed {
      logic               valid;
      mode_type           mode;
      logic [ENTRY_W-1:0] entry_index;
      color_type          pixel;
      logic [MATCH_W-1:0] best_index;
      color_type          best_color;
      logic [DIST_W-1:0]  best_distance;
   } cell_bus_type;

   function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0]   d;
      logic [2*CHAN_W-1:0] dw;
      d  = (a > b) ? (a - b) : (b - a);
      dw = {{CHAN_W{1'b0}}, d};
      return dw * dw;
   endfunction

   function automatic logic [DIST_W-1:0] color_distance(input color_type p,
                                                        input color_type c);
      return DIST_W'(sq_diff(p.red, c.red))
           + DIST_W'(sq_diff(p.green, c.green))
           + DIST_W'(sq_diff(p.blue, c.blue));
   endfunction

   // entries taking part in the search: zero counts as one, saturates at depth
   function automatic logic [COUNT_W-1:0] active_count(input logic [SIZE_W-1:0] size);
      logic [COUNT_W-1:0] n;
      if (size == '0) begin
         n = COUNT_W'(1);
      end else if (int'(size) > PALETTE_DEPTH) begin
         n = COUNT_W'(PALETTE_DEPTH);
      end else begin
         n = COUNT_W'(size);
      end
      return n;
   endfunction

endpackage

// ===== rtl/npq_cell.sv =====
module npq_cell
   import npq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [MATCH_W-1:0] cell_index,
   input  logic               active,
   input  cell_bus_type       up_bus,
   output cell_bus_type       down_bus
);

   color_type         entry_ff, entry_in;
   cell_bus_type      bus_ff, bus_in;
   logic [DIST_W-1:0] distance;
   logic              load_hit;
   logic              take;

   always_comb begin
      distance = color_distance(up_bus.pixel, entry_ff);
      load_hit = up_bus.valid && (up_bus.mode == MODE_LOAD)
                 && (MATCH_W'(up_bus.entry_index) == cell_index);
      // strict less keeps the lowest index on ties
      take     = (up_bus.mode == MODE_PIXEL) && active
                 && (distance < up_bus.best_distance);
      entry_in = load_hit ? up_bus.pixel : entry_ff;
      bus_in   = up_bus;
      if (take) begin
         bus_in.best_index    = cell_index;
         bus_in.best_color    = entry_ff;
         bus_in.best_distance = distance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff.valid <= 1'b0;
      end else if (advance) begin
         bus_ff <= bus_in;
      end
   end

   assign down_bus = bus_ff;

endmodule

// ===== rtl/nearest_palette_color_quantizer_core.sv =====
// Nearest palette colour quantizer. A row of PALETTE_DEPTH cells, each holding
// one 24-bit palette entry, passes every item one cell onwards per cycle unless
// the row is stalled. A load transfer (tuser low) writes the cell whose slot
// matches entry_index as it passes; a pixel transfer (tuser high) picks up the
// squared RGB distance in every active cell and keeps the closest entry, the
// lowest index on ties. One item is taken per cycle unless stalled; a pixel's
// result leaves the last cell's register, loads give none. When a result is
// held back by rsp_tready low the whole row freezes and req_tready drops.
// Because items keep their order along the row, a pixel always sees every load
// sent before it and none sent after it. palette_size (reset 1) selects how
// many entries from slot 0 are searched; zero acts as one and values above the
// depth saturate. The user must write it over the csr port only while no pixel
// is in flight; the block does not enforce this. Palette entries come out of
// reset undefined and must be loaded before a pixel searches them.
module nearest_palette_color_quantizer_core
   import npq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry_index[3:0], red[11:4], green[19:12], blue[27:20], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode: 0 load palette entry, 1 quantize pixel
   input  logic                  req_tuser,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // best_index[3:0], out_red[11:4], out_green[19:12], out_blue[27:20],
   // best_distance[45:28], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [SIZE_W-1:0]     csr_data
);

   logic [SIZE_W-1:0]        size_ff, size_in;
   logic [COUNT_W-1:0]       count;
   logic [PALETTE_DEPTH-1:0] active;
   logic                     advance;
   cell_bus_type             head;
   cell_bus_type             chain [PALETTE_DEPTH+1];
   cell_bus_type             last;

   // palette size register, always ready
   assign csr_ready = 1'b1;
   assign size_in   = (csr_valid && csr_ready) ? csr_data : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(1);
      end else begin
         size_ff <= size_in;
      end
   end

   assign count = active_count(size_ff);

   // whole row moves unless a result is waiting and not taken
   assign last       = chain[PALETTE_DEPTH];
   assign rsp_tvalid = last.valid && (last.mode == MODE_PIXEL);
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // head of the row: unpack the transfer, start with no match
   always_comb begin
      head.valid            = req_tvalid;
      head.mode             = mode_type'(req_tuser);
      head.entry_index      = req_tdata[ENTRY_W-1:0];
      head.pixel.red        = req_tdata[ENTRY_W +: CHAN_W];
      head.pixel.green      = req_tdata[ENTRY_W+CHAN_W +: CHAN_W];
      head.pixel.blue       = req_tdata[ENTRY_W+2*CHAN_W +: CHAN_W];
      head.best_index       = '0;
      head.best_color       = '0;
      head.best_distance    = DIST_INIT;
   end

   assign chain[0] = head;

   for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
      assign active[k] = COUNT_W'(k) < count;

      npq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (MATCH_W'(k)),
         .active     (active[k]),
         .up_bus     (chain[k]),
         .down_bus   (chain[k+1])
      );
   end

   // result packing, index masked to its field
   assign rsp_tdata = {{(RSP_DATA_W-RSP_FIELD_W){1'b0}},
                       last.best_distance,
                       last.best_color.blue,
                       last.best_color.green,
                       last.best_color.red,
                       ENTRY_W'(last.best_index)};

   // entry 0 is always searched, so a result never carries the start value
   a_dist_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (last.best_distance != DIST_INIT))
      else $error("result distance never updated");

   // winning slot lies inside the searched part of the palette
   a_index_active: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(last.best_index) < int'(count)))
      else $error("winning slot outside active entries");

   // a stalled row keeps its result in place
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> rsp_tvalid)
      else $error("result lost during stall");

   // input is refused exactly while a result is held back
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while row stalled");

endmodule
